// ===== hdl/hgl_pkg.sv =====
// ----------------------------------------------------------------------------
// hgl_pkg
// Shared types, codes and helpers of the hex glyph line parser.
// ----------------------------------------------------------------------------
package hgl_pkg;

  // Default limit on the number of codepoint digits in a line.
  localparam int MAX_CODE_DIGITS_DEF = 6;

  // Fixed widths and counts of the line format.
  localparam int CODE_W        = 24;
  localparam int BM_CNT_W      = 7;
  localparam int NARROW_DIGITS = 32;
  localparam int WIDE_DIGITS   = 64;
  localparam int ROWS          = 16;
  localparam int TILE_IDX_W    = 5;
  localparam int RAM_ADDR_W    = 6;
  localparam logic [7:0] COLON_CHAR = 8'h3A;

  // Item kinds on the character channel.
  typedef enum logic {
    KIND_TEXT = 1'b0,
    KIND_EOL  = 1'b1
  } kind_t;

  // Line status codes, in the order of their priority after success.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_COLON   = 3'd1,
    ST_BAD_CODE   = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BAD_DIGIT  = 3'd4
  } status_t;

  // One finished line waiting for the back end.
  typedef struct packed {
    status_t             status;
    logic [CODE_W-1:0]   codepoint;
    logic                wide;
    logic                bank;
  } job_t;

  // Push request from the front end to the job queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  // Write port of the row byte buffer.
  typedef struct packed {
    logic                  en;
    logic [RAM_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } row_wr_t;

  // Description of one result as it moves down the back end.
  typedef struct packed {
    status_t               status;
    logic [CODE_W-1:0]     codepoint;
    logic                  wide;
    logic [TILE_IDX_W-1:0] idx;
    logic                  last;
  } tile_meta_t;

  // Hex digit value of a character; 16 marks a character that is not hex.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

// ===== hdl/hgl_in_if.sv =====
// ----------------------------------------------------------------------------
// hgl_in_if
// Character channel: one text character or an end of line per transaction.
// ----------------------------------------------------------------------------
interface hgl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

// ===== hdl/hgl_out_if.sv =====
// ----------------------------------------------------------------------------
// hgl_out_if
// Result channel: one status or tile byte per transaction.
// ----------------------------------------------------------------------------
interface hgl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [23:0] glyph_codepoint;
  logic        wide_glyph;
  logic [4:0]  tile_index;
  logic [7:0]  tile_byte;
  logic        last_of_line;

  modport source (output valid, output status, output glyph_codepoint,
                  output wide_glyph, output tile_index, output tile_byte,
                  output last_of_line, input ready);
  modport sink   (input valid, input status, input glyph_codepoint,
                  input wide_glyph, input tile_index, input tile_byte,
                  input last_of_line, output ready);
endinterface

// ===== hdl/hex_glyph_line_parser_core.sv =====
// A line's first result passes the job queue, read stage and output register. Throughput:
// one character per cycle while the queue has room; results, while the receiver is ready,
// one per cycle: 16 or 32 per good line, one per failed line, as the next line is parsed.
// Characters stall only while two finished lines hold both banks of the row buffer.
// Reset (rst, synchronous) clears the line state, the job queue and the output stages.
// ----------------------------------------------------------------------------
// hex_glyph_line_parser_core
// Hex bitmap-font line parser: front end, job queue and tile play-out.
// ----------------------------------------------------------------------------
module hex_glyph_line_parser_core #(
  parameter int MAX_CODE_DIGITS = hgl_pkg::MAX_CODE_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hgl_in_if.sink     chars,
  hgl_out_if.source  tiles
);
  import hgl_pkg::*;

  job_push_t push;
  row_wr_t   wr;
  logic      q_full;
  logic      q_not_empty;
  logic      pop;
  job_t      head;

  hgl_front #(
    .MAX_CODE_DIGITS(MAX_CODE_DIGITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .q_full (q_full),
    .push   (push),
    .wr     (wr)
  );

  hgl_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  hgl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .job_valid (q_not_empty),
    .job       (head),
    .pop       (pop),
    .tiles     (tiles)
  );

endmodule

// ===== hdl/hgl_front.sv =====
// ----------------------------------------------------------------------------
// hgl_front
// Parses characters into line state and row bytes, and queues a job per line.
// ----------------------------------------------------------------------------
module hgl_front #(
  parameter int MAX_CODE_DIGITS = hgl_pkg::MAX_CODE_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  hgl_in_if.sink              chars,
  input  logic                q_full,
  output hgl_pkg::job_push_t  push,
  output hgl_pkg::row_wr_t    wr
);
  import hgl_pkg::*;

  localparam int CntW = $clog2(MAX_CODE_DIGITS + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_CODE_DIGITS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_CODE_DIGITS);

  logic                colon_seen, colon_seen_next;
  logic [CODE_W-1:0]   code_accum, code_accum_next;
  logic [CntW-1:0]     code_cnt, code_cnt_next;
  logic                code_bad, code_bad_next;
  logic [BM_CNT_W-1:0] bm_cnt, bm_cnt_next;
  logic                bm_bad, bm_bad_next;
  logic [3:0]          high_nibble, high_nibble_next;
  logic                bank;

  logic       accept;
  logic       is_eol;
  logic [4:0] digit;
  logic       is_hex;
  logic [3:0] nib;
  status_t    status;

  // An item is taken whenever a slot for a finished line is free.
  assign chars.ready = !q_full;
  assign accept      = chars.valid && chars.ready;
  assign is_eol      = (chars.kind == KIND_EOL);
  assign digit       = hex_value(chars.text_byte);
  assign is_hex      = !digit[4];
  assign nib         = is_hex ? digit[3:0] : 4'd0;

  // Classify the line at its end, in priority order.
  always_comb begin
    if (!colon_seen) begin
      status = ST_NO_COLON;
    end else if (code_cnt == '0 || code_cnt > CntMax || code_bad) begin
      status = ST_BAD_CODE;
    end else if (bm_cnt != BM_CNT_W'(NARROW_DIGITS) && bm_cnt != BM_CNT_W'(WIDE_DIGITS)) begin
      status = ST_BAD_LENGTH;
    end else if (bm_bad) begin
      status = ST_BAD_DIGIT;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    push.valid         = accept && is_eol;
    push.job.status    = status;
    push.job.codepoint = (status == ST_NO_COLON || status == ST_BAD_CODE) ? '0 : code_accum;
    push.job.wide      = (status == ST_OK) && (bm_cnt == BM_CNT_W'(WIDE_DIGITS));
    push.job.bank      = bank;
  end

  // Every second bitmap digit completes a row byte.
  assign wr.en   = accept && !is_eol && colon_seen && (bm_cnt < BM_CNT_W'(WIDE_DIGITS))
                   && bm_cnt[0];
  assign wr.addr = {bank, bm_cnt[5:1]};
  assign wr.data = {high_nibble, nib};

  // Next line state for a text character; an end of line clears it.
  always_comb begin
    colon_seen_next  = colon_seen;
    code_accum_next  = code_accum;
    code_cnt_next    = code_cnt;
    code_bad_next    = code_bad;
    bm_cnt_next      = bm_cnt;
    bm_bad_next      = bm_bad;
    high_nibble_next = high_nibble;
    if (is_eol) begin
      colon_seen_next  = 1'b0;
      code_accum_next  = '0;
      code_cnt_next    = '0;
      code_bad_next    = 1'b0;
      bm_cnt_next      = '0;
      bm_bad_next      = 1'b0;
      high_nibble_next = '0;
    end else if (!colon_seen) begin
      if (chars.text_byte == COLON_CHAR) begin
        colon_seen_next = 1'b1;
      end else begin
        if (!is_hex) begin
          code_bad_next = 1'b1;
        end else begin
          code_accum_next = {code_accum[CODE_W-5:0], digit[3:0]};
        end
        if (code_cnt < CntSat) begin
          code_cnt_next = code_cnt + 1'b1;
        end
      end
    end else begin
      if (!is_hex) begin
        bm_bad_next = 1'b1;
      end
      if (bm_cnt < BM_CNT_W'(WIDE_DIGITS) && !bm_cnt[0]) begin
        high_nibble_next = nib;
      end
      if (bm_cnt < BM_CNT_W'(WIDE_DIGITS + 1)) begin
        bm_cnt_next = bm_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colon_seen  <= 1'b0;
      code_accum  <= '0;
      code_cnt    <= '0;
      code_bad    <= 1'b0;
      bm_cnt      <= '0;
      bm_bad      <= 1'b0;
      high_nibble <= '0;
      bank        <= 1'b0;
    end else if (accept) begin
      colon_seen  <= colon_seen_next;
      code_accum  <= code_accum_next;
      code_cnt    <= code_cnt_next;
      code_bad    <= code_bad_next;
      bm_cnt      <= bm_cnt_next;
      bm_bad      <= bm_bad_next;
      high_nibble <= high_nibble_next;
      if (is_eol) begin
        bank <= !bank;
      end
    end
  end

endmodule

// ===== hdl/hgl_job_queue.sv =====
// ----------------------------------------------------------------------------
// hgl_job_queue
// Two-entry queue of finished lines between the front and back ends.
// ----------------------------------------------------------------------------
module hgl_job_queue (
  input  logic               clk,
  input  logic               rst,
  input  hgl_pkg::job_push_t push,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output hgl_pkg::job_t      head
);
  import hgl_pkg::*;

  job_t       entries [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  // Entry storage holds payload only.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/hgl_back.sv =====
// ----------------------------------------------------------------------------
// hgl_back
// Holds the double-banked row buffer and plays each line out as results.
// ----------------------------------------------------------------------------
module hgl_back (
  input  logic             clk,
  input  logic             rst,
  input  hgl_pkg::row_wr_t wr,
  input  logic             job_valid,
  input  hgl_pkg::job_t    job,
  output logic             pop,
  hgl_out_if.source        tiles
);
  import hgl_pkg::*;

  localparam int RamDepth = 1 << RAM_ADDR_W;

  logic [7:0]            ram [RamDepth];
  logic [7:0]            rd_data;
  logic [RAM_ADDR_W-1:0] rd_addr;
  logic                  rd_en;

  logic [TILE_IDX_W-1:0] issue_idx;
  logic                  issue_last;
  tile_meta_t            issue_meta;

  logic       f_valid;
  tile_meta_t f_meta;
  logic       out_valid;
  tile_meta_t out_meta;
  logic [7:0] out_byte;
  logic       out_load;

  // Last result of the job: the only one for an error, else row 15 or 31.
  always_comb begin
    if (job.status != ST_OK) begin
      issue_last = 1'b1;
    end else if (job.wide) begin
      issue_last = (issue_idx == TILE_IDX_W'(2 * ROWS - 1));
    end else begin
      issue_last = (issue_idx == TILE_IDX_W'(ROWS - 1));
    end
  end

  always_comb begin
    issue_meta.status    = job.status;
    issue_meta.codepoint = job.codepoint;
    issue_meta.wide      = job.wide;
    issue_meta.idx       = (job.status == ST_OK) ? issue_idx : '0;
    issue_meta.last      = issue_last;
  end

  // Wide glyphs are read column-major from row-major storage.
  assign rd_addr = job.wide ? {job.bank, issue_idx[3:0], issue_idx[4]}
                            : {job.bank, issue_idx};

  // Two-stage flow: buffer read, then output register.
  assign out_load = f_valid && (!out_valid || tiles.ready);
  assign rd_en    = job_valid && (!f_valid || out_load);
  assign pop      = rd_en && issue_last;

  // Row buffer: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      ram[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= ram[rd_addr];
    end
  end

  // Payload registers of the read and output stages.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      f_meta <= issue_meta;
    end
    if (out_load) begin
      out_meta <= f_meta;
      out_byte <= (f_meta.status == ST_OK) ? rd_data : 8'd0;
    end
  end

  // Sequencer and stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_idx <= '0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        issue_idx <= '0;
      end else if (rd_en) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (rd_en) begin
        f_valid <= 1'b1;
      end else if (out_load) begin
        f_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (tiles.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tiles.valid           = out_valid;
  assign tiles.status          = out_meta.status;
  assign tiles.glyph_codepoint = out_meta.codepoint;
  assign tiles.wide_glyph      = out_meta.wide;
  assign tiles.tile_index      = out_meta.idx;
  assign tiles.tile_byte       = out_byte;
  assign tiles.last_of_line    = out_meta.last;

endmodule

// ===== hdl/hgl_checker.sv =====
// ----------------------------------------------------------------------------
// hgl_checker
// Port-level checks on the result channel of the line parser.
// ----------------------------------------------------------------------------
module hgl_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [2:0]  status,
  input logic [23:0] glyph_codepoint,
  input logic        wide_glyph,
  input logic [4:0]  tile_index,
  input logic [7:0]  tile_byte,
  input logic        last_of_line
);
  import hgl_pkg::*;

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable({status, glyph_codepoint, wide_glyph,
                                           tile_index, tile_byte, last_of_line}))
    else $error("result changed while stalled");

  // A failed line gives one closing result with no tile data.
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    valid && status != ST_OK |-> last_of_line && tile_index == '0 && tile_byte == '0
                                 && !wide_glyph)
    else $error("malformed error result");

  // A good line closes on row 15 of a narrow glyph or index 31 of a wide one.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    valid && status == ST_OK && last_of_line |->
      (wide_glyph && tile_index == 5'd31) || (!wide_glyph && tile_index == 5'd15))
    else $error("line closed at wrong tile");

  // Tile bytes of one line come in consecutive order with a fixed codepoint.
  a_tile_order: assert property (@(posedge clk) disable iff (rst)
    valid && ready && status == ST_OK && !last_of_line ##1 valid |->
      status == ST_OK && tile_index == $past(tile_index) + 5'd1
      && glyph_codepoint == $past(glyph_codepoint))
    else $error("tile sequence broken");

endmodule

bind hex_glyph_line_parser_core hgl_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .valid           (tiles.valid),
  .ready           (tiles.ready),
  .status          (tiles.status),
  .glyph_codepoint (tiles.glyph_codepoint),
  .wide_glyph      (tiles.wide_glyph),
  .tile_index      (tiles.tile_index),
  .tile_byte       (tiles.tile_byte),
  .last_of_line    (tiles.last_of_line)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hex glyph line parser. Whole text lines are fed
// in one character per transaction, each closed by an end of line. A local
// line model predicts the status and tile bytes of every line. Each result
// transaction is compared field by field with the oldest prediction. Both
// sides idle in random bursts, and one long output stall fills the block.
// ----------------------------------------------------------------------------
module tb_top;
  import hgl_pkg::*;

  localparam int MAXD        = MAX_CODE_DIGITS_DEF;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 500000;

  // One predicted result transaction.
  typedef struct packed {
    status_t     status;
    logic [23:0] codepoint;
    logic        wide;
    logic [4:0]  idx;
    logic [7:0]  row_byte;
    logic        last;
  } tile_result_t;

  logic clk = 1'b0;
  logic rst;

  hgl_in_if  chars_if ();
  hgl_out_if tiles_if ();

  hex_glyph_line_parser_core uut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_if),
    .tiles (tiles_if)
  );

  // Line model state.
  bit          in_bitmap;
  logic [23:0] code_value;
  int          code_digits;
  bit          code_has_bad;
  int          bitmap_digits;
  bit          bitmap_has_bad;
  logic [3:0]  pending_nibble;
  logic [7:0]  glyph_rows [32];

  tile_result_t expected_tiles [$];
  logic [7:0]   line_buf [$];

  int  errors        = 0;
  int  hold_requests = 0;
  int  cycle_count   = 0;
  bit  send_idle_on  = 1'b1;
  bit  recv_idle_on  = 1'b1;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Value of a hex digit; bit 4 set marks a character that is not hex.
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h57);
    end
    return d;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void push_tile(input status_t st, input logic [23:0] cp,
                                    input logic wide, input logic [4:0] idx,
                                    input logic [7:0] row_byte, input logic last);
    tile_result_t r;
    r.status    = st;
    r.codepoint = cp;
    r.wide      = wide;
    r.idx       = idx;
    r.row_byte  = row_byte;
    r.last      = last;
    expected_tiles.insert(expected_tiles.size(), r);
  endfunction

  // Close a line: work out its status and, for a good line, its tile bytes.
  function automatic void close_line();
    if (!in_bitmap) begin
      push_tile(ST_NO_COLON, 24'd0, 1'b0, 5'd0, 8'd0, 1'b1);
    end else if (code_digits < 1 || code_digits > MAXD || code_has_bad) begin
      push_tile(ST_BAD_CODE, 24'd0, 1'b0, 5'd0, 8'd0, 1'b1);
    end else if (bitmap_digits != NARROW_DIGITS && bitmap_digits != WIDE_DIGITS) begin
      push_tile(ST_BAD_LENGTH, code_value, 1'b0, 5'd0, 8'd0, 1'b1);
    end else if (bitmap_has_bad) begin
      push_tile(ST_BAD_DIGIT, code_value, 1'b0, 5'd0, 8'd0, 1'b1);
    end else if (bitmap_digits == NARROW_DIGITS) begin
      for (int row = 0; row < ROWS; row++) begin
        push_tile(ST_OK, code_value, 1'b0, 5'(row), glyph_rows[row], row == ROWS - 1);
      end
    end else begin
      // Wide glyphs leave column by column: all left bytes, then all right bytes.
      for (int col = 0; col < 2; col++) begin
        for (int row = 0; row < ROWS; row++) begin
          push_tile(ST_OK, code_value, 1'b1, 5'(col * ROWS + row),
                    glyph_rows[row * 2 + col], col == 1 && row == ROWS - 1);
        end
      end
    end
    in_bitmap      = 1'b0;
    code_value     = '0;
    code_digits    = 0;
    code_has_bad   = 1'b0;
    bitmap_digits  = 0;
    bitmap_has_bad = 1'b0;
    pending_nibble = '0;
  endfunction

  // Advance the line model by one accepted character or end of line.
  function automatic void parse_item(input logic k, input logic [7:0] c);
    logic [4:0] d;
    d = digit_of(c);
    if (k == KIND_EOL) begin
      close_line();
    end else if (!in_bitmap) begin
      if (c == COLON_CHAR) begin
        in_bitmap = 1'b1;
      end else begin
        if (d[4]) begin
          code_has_bad = 1'b1;
        end else begin
          code_value = {code_value[19:0], d[3:0]};
        end
        if (code_digits < MAXD + 1) begin
          code_digits++;
        end
      end
    end else begin
      // Every character after the colon counts as a bitmap digit.
      if (d[4]) begin
        bitmap_has_bad = 1'b1;
        d = 5'd0;
      end
      if (bitmap_digits < WIDE_DIGITS) begin
        if (bitmap_digits % 2 == 0) begin
          pending_nibble = d[3:0];
        end else begin
          glyph_rows[bitmap_digits / 2] = {pending_nibble, d[3:0]};
        end
      end
      if (bitmap_digits < WIDE_DIGITS + 1) begin
        bitmap_digits++;
      end
    end
  endfunction

  // Compare one result transaction with the oldest prediction.
  task automatic check_tile();
    tile_result_t want;
    if (expected_tiles.size() == 0) begin
      report_error($sformatf("result with none expected: status %0d index %0d",
                             tiles_if.status, tiles_if.tile_index));
    end else begin
      want = expected_tiles.pop_front();
      if (tiles_if.status !== want.status) begin
        report_error($sformatf("status %0d, expected %0d", tiles_if.status, want.status));
      end
      if (tiles_if.glyph_codepoint !== want.codepoint) begin
        report_error($sformatf("codepoint %h, expected %h",
                               tiles_if.glyph_codepoint, want.codepoint));
      end
      if (tiles_if.wide_glyph !== want.wide) begin
        report_error($sformatf("wide %b, expected %b", tiles_if.wide_glyph, want.wide));
      end
      if (tiles_if.tile_index !== want.idx) begin
        report_error($sformatf("tile index %0d, expected %0d",
                               tiles_if.tile_index, want.idx));
      end
      if (tiles_if.tile_byte !== want.row_byte) begin
        report_error($sformatf("tile byte %h, expected %h at index %0d",
                               tiles_if.tile_byte, want.row_byte, want.idx));
      end
      if (tiles_if.last_of_line !== want.last) begin
        report_error($sformatf("last of line %b, expected %b at index %0d",
                               tiles_if.last_of_line, want.last, want.idx));
      end
    end
  endtask

  // Watch both channels: predict on each accepted character, check each result.
  always @(posedge clk) begin
    if (!rst) begin
      if (chars_if.valid === 1'b1 && chars_if.ready === 1'b1) begin
        parse_item(chars_if.kind, chars_if.text_byte);
      end
      if (tiles_if.valid === 1'b1 && tiles_if.ready === 1'b1) begin
        check_tile();
      end
    end
  end

  // Result receiver: random stalls, plus a long hold whenever one is requested.
  initial begin
    int stall_left;
    int hold_left;
    int hold_served;
    stall_left      = 0;
    hold_left       = 0;
    hold_served     = 0;
    tiles_if.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        tiles_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        tiles_if.ready <= 1'b0;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        tiles_if.ready <= 1'b0;
      end else begin
        tiles_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Offer one transaction, with an occasional idle burst first, and wait for it.
  task automatic send_item(input kind_t k, input logic [7:0] c);
    int gap;
    if (send_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.kind      <= k;
    chars_if.text_byte <= c;
    @(posedge clk);
    while (chars_if.ready !== 1'b1) @(posedge clk);
  endtask

  // Send the characters held in line_buf and then the end of line.
  task automatic send_line();
    foreach (line_buf[i]) begin
      send_item(KIND_TEXT, line_buf[i]);
    end
    send_item(KIND_EOL, 8'($urandom_range(0, 255)));
    line_buf.delete();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + n;
    end else if ($urandom_range(0, 1) == 0) begin
      c = 8'h41 + (n - 4'd10);
    end else begin
      c = 8'h61 + (n - 4'd10);
    end
    return c;
  endfunction

  function automatic void put_hex(input int n);
    repeat (n) line_buf.insert(line_buf.size(), hex_char(4'($urandom_range(0, 15))));
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_buf.insert(line_buf.size(), s[i]);
    end
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (digit_of(c) < 5'd16 || c == COLON_CHAR);
    return c;
  endfunction

  // Lines without a colon, the empty line among them.
  task automatic test_no_colon();
    send_line();
    put_text("zz!");
    line_buf.insert(line_buf.size(), 8'h0D);
    line_buf.insert(line_buf.size(), 8'hFF);
    send_line();
  endtask

  // Codepoints with no digits, too many digits or a character that is not hex.
  // Each of these lines also has a wrong bitmap length, which a bad codepoint outranks.
  task automatic test_bad_codepoint();
    put_text(":");
    put_hex(1);
    send_line();
    put_text("1234567:");
    send_line();
    // Characters just outside the hex ranges.
    put_text("/@G`g:");
    send_line();
  endtask

  // Bitmap lengths other than 32 and 64, saturation past 64 included.
  task automatic test_bitmap_length();
    int lengths [2] = '{0, 65};
    foreach (lengths[i]) begin
      put_text("41:");
      put_hex(lengths[i]);
      send_line();
    end
    // A wrong length outranks a bad bitmap digit.
    put_text("41:");
    line_buf.insert(line_buf.size(), pick_non_hex());
    send_line();
  endtask

  // A bitmap of the right length holding characters that are not hex: a
  // carriage return and a second colon both count as bitmap digits.
  task automatic test_bad_bitmap_digit();
    put_text("7:");
    put_hex(NARROW_DIGITS - 2);
    line_buf.insert(line_buf.size(), 8'h0D);
    line_buf.insert(line_buf.size(), COLON_CHAR);
    send_line();
  endtask

  // A good wide glyph at the top of the codepoint range.
  task automatic test_good_glyphs();
    put_text("FFFFFF:");
    put_hex(WIDE_DIGITS);
    send_line();
  endtask

  // Hold the receiver off for a long stretch while lines keep coming.
  task automatic test_output_backpressure();
    send_idle_on  = 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (6) begin
      put_text("q");
      send_line();
    end
    send_idle_on = 1'b1;
  endtask

  // Back-to-back lines with no idling on either side.
  task automatic test_steady_stream();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    put_text("a:0123456789ABCDEFabcdef0123456789");
    send_line();
    put_text("0:");
    put_hex(3);
    send_line();
  endtask

  // Test sequence.
  initial begin
    in_bitmap          = 1'b0;
    code_value         = '0;
    code_digits        = 0;
    code_has_bad       = 1'b0;
    bitmap_digits      = 0;
    bitmap_has_bad     = 1'b0;
    pending_nibble     = '0;
    chars_if.valid     = 1'b0;
    chars_if.kind      = KIND_TEXT;
    chars_if.text_byte = 8'h00;
    rst                = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_no_colon();
    test_bad_codepoint();
    test_bitmap_length();
    test_bad_bitmap_digit();
    test_good_glyphs();
    test_output_backpressure();
    test_steady_stream();

    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hgl_pkg.sv
hdl/hgl_in_if.sv
hdl/hgl_out_if.sv
hdl/hgl_front.sv
hdl/hgl_job_queue.sv
hdl/hgl_back.sv
hdl/hex_glyph_line_parser_core.sv
hdl/hgl_checker.sv
test/tb_top.sv
